// ----- rtl/core/rhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants for the RGB to HSV pixel core.
// ----------------------------------------------------------------------------
package rhp_pkg;

    localparam int PIX_W      = 8;
    localparam int QUO_W      = 8;   // both quotients fit one byte
    localparam int HUE_REM_W  = 21;  // 17 * 91800 < 2**21
    localparam int HUE_DEN_W  = 13;  // 24 * 255 < 2**13
    localparam int SAT_REM_W  = 16;  // 255 * 255 < 2**16
    localparam int SAT_DEN_W  = 8;
    localparam int SCALED_W   = 19;  // signed base*delta + 60*n
    localparam int NUM_CELLS  = QUO_W;

    // Sector of the hue, by which component is largest
    typedef enum logic [1:0] {
        SEC_RED_POS  = 2'd0,
        SEC_RED_WRAP = 2'd1,
        SEC_GREEN    = 2'd2,
        SEC_BLUE     = 2'd3
    } t_sector;

    typedef struct packed {
        logic                 vld;
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [QUO_W-1:0]     hue_q;
        logic [SAT_REM_W-1:0] sat_rem;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [QUO_W-1:0]     sat_q;
        logic [PIX_W-1:0]     bright;
    } t_cell_data;

endpackage

// ----- rtl/core/rhp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_front
// Two stages: max/min/sector, then dividends and divisors for the cells.
// ----------------------------------------------------------------------------
module rhp_front
    import rhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output t_cell_data       o_data
);

    logic                       r_s1_vld;
    logic [PIX_W-1:0]           r_mx, n_mx;
    logic [PIX_W-1:0]           r_delta, n_delta;
    t_sector                    r_sec, n_sec;
    logic signed [PIX_W:0]      r_diff, n_diff;

    logic [PIX_W-1:0]           mn;
    logic signed [SCALED_W-1:0] base_term;
    logic signed [SCALED_W-1:0] scaled;
    t_cell_data                 r_out, n_out;

    always_comb begin
        n_mx = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx) n_mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        n_delta = n_mx - mn;
        if (n_mx == i_red && i_green >= i_blue) begin
            n_sec  = SEC_RED_POS;
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (n_mx == i_red) begin
            n_sec  = SEC_RED_WRAP;
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (n_mx == i_green) begin
            n_sec  = SEC_GREEN;
            n_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sec  = SEC_BLUE;
            n_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_valid;
        end
        if (i_en) begin
            r_mx    <= n_mx;
            r_delta <= n_delta;
            r_sec   <= n_sec;
            r_diff  <= n_diff;
        end
    end

    // hue = floor(17*scaled / (24*delta)); sat = floor(255*delta / max)
    always_comb begin
        case (r_sec)
            SEC_RED_POS:  base_term = '0;
            SEC_RED_WRAP: base_term = $signed({{(SCALED_W-PIX_W){1'b0}}, r_delta})
                                      * SCALED_W'(360);
            SEC_GREEN:    base_term = $signed({{(SCALED_W-PIX_W){1'b0}}, r_delta})
                                      * SCALED_W'(120);
            SEC_BLUE:     base_term = $signed({{(SCALED_W-PIX_W){1'b0}}, r_delta})
                                      * SCALED_W'(240);
            default:      base_term = '0;
        endcase
        scaled = base_term + SCALED_W'(r_diff) * SCALED_W'(60);
        if (scaled < 0) scaled = '0;

        n_out         = '0;
        n_out.vld     = r_s1_vld;
        n_out.bright  = r_mx;
        n_out.hue_rem = HUE_REM_W'(scaled[SCALED_W-2:0]) * HUE_REM_W'(17);
        n_out.sat_rem = SAT_REM_W'(r_delta) * SAT_REM_W'(255);
        // grey or black: all-ones divisor with zero dividend yields zero
        if (r_delta == '0) begin
            n_out.hue_den = '1;
            n_out.hue_rem = '0;
        end else begin
            n_out.hue_den = HUE_DEN_W'(r_delta) * HUE_DEN_W'(24);
        end
        if (r_mx == '0) begin
            n_out.sat_den = '1;
            n_out.sat_rem = '0;
        end else begin
            n_out.sat_den = r_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ----- rtl/core/rhp_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_div_cell
// One restoring-division step for hue and saturation: one quotient bit each.
// ----------------------------------------------------------------------------
module rhp_div_cell
    import rhp_pkg::*;
#(
    parameter int BIT_IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_data i_data,
    output t_cell_data o_data
);

    logic [HUE_REM_W-1:0] hue_sh;
    logic [SAT_REM_W-1:0] sat_sh;
    t_cell_data           r_data, n_data;

    always_comb begin
        n_data = i_data;
        hue_sh = HUE_REM_W'(i_data.hue_den) << BIT_IDX;
        sat_sh = SAT_REM_W'(i_data.sat_den) << BIT_IDX;
        if (i_data.hue_rem >= hue_sh) begin
            n_data.hue_rem        = i_data.hue_rem - hue_sh;
            n_data.hue_q[BIT_IDX] = 1'b1;
        end
        if (i_data.sat_rem >= sat_sh) begin
            n_data.sat_rem        = i_data.sat_rem - sat_sh;
            n_data.sat_q[BIT_IDX] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.vld <= 1'b0;
        end else if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- rtl/core/rgb_to_hsv_pixel_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_core
// 8-bit RGB to 8-bit HSV, pipelined through a chain of divider cells.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  pixel   | i_valid o_ready i_red i_green i_blue     | in
//  hsv     | o_valid i_ready o_hue o_saturation       | out
//          | o_brightness                             |
//
// One beat per cycle while the output is not stalled; 2 front stages, then one
// cell per quotient bit, 8 cells. Synchronous active-low reset clears the
// valid bits only. A stall on the output freezes the whole pipe in place;
// o_ready is high whenever the last stage is empty or being drained.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_core
    import rhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_hue,
    output logic [PIX_W-1:0] o_saturation,
    output logic [PIX_W-1:0] o_brightness
);

    // one cell per quotient bit
    localparam int N_CELLS = NUM_CELLS;

    t_cell_data chain [N_CELLS+1];
    logic       en;

    assign en = !chain[N_CELLS].vld || i_ready;

    rhp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_data  (chain[0])
    );

    // cell k settles quotient bit N_CELLS-1-k
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        rhp_div_cell #(
            .BIT_IDX (N_CELLS-1-k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_data  (chain[k]),
            .o_data  (chain[k+1])
        );
    end

    assign o_ready      = en;
    assign o_valid      = chain[N_CELLS].vld;
    assign o_hue        = chain[N_CELLS].hue_q;
    assign o_saturation = chain[N_CELLS].sat_q;
    assign o_brightness = chain[N_CELLS].bright;

endmodule

// ----- rtl/core/rhp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_checker
// Port-level checks for the RGB to HSV pixel core.
// ----------------------------------------------------------------------------
module rhp_checker
    import rhp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic [PIX_W-1:0] i_red,
    input logic [PIX_W-1:0] i_green,
    input logic [PIX_W-1:0] i_blue,
    input logic             o_valid,
    input logic             i_ready,
    input logic [PIX_W-1:0] o_hue,
    input logic [PIX_W-1:0] o_saturation,
    input logic [PIX_W-1:0] o_brightness
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hue)
            && $stable(o_saturation) && $stable(o_brightness))
        else $error("output beat changed while stalled");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue != 8'hFF)
        else $error("hue out of range");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == '0 |-> o_saturation == '0)
        else $error("black pixel with nonzero saturation");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation == '0 |-> o_hue == '0)
        else $error("grey pixel with nonzero hue");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind rgb_to_hsv_pixel_core rhp_checker u_rhp_checker (.*);

// ----- verif/tb_rgb_to_hsv_pixel_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel_core
// Drives RGB pixels through the core with random bursts, gaps and output
// stalls, predicts each HSV result with exact integer math and compares
// every beat in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel_core;
    import rhp_pkg::*;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } t_hsv;

    int n_errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    class hsv_scoreboard;
        t_hsv pending[$];

        function t_hsv convert(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
            int mx, mn, d, base, n, scaled;
            t_hsv res;
            mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
            mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
            d = mx - mn;
            res.val = mx[7:0];
            res.sat = (mx == 0) ? 8'd0 : 8'((255 * d) / mx);
            if (d == 0) begin
                res.hue = 8'd0;
            end else begin
                if (mx == r && g >= b) begin
                    base = 0; n = int'(g) - int'(b);
                end else if (mx == r) begin
                    base = 360; n = int'(g) - int'(b);
                end else if (mx == g) begin
                    base = 120; n = int'(b) - int'(r);
                end else begin
                    base = 240; n = int'(r) - int'(g);
                end
                scaled = base * d + 60 * n;
                if (scaled < 0) scaled = 0;
                res.hue = 8'((255 * scaled) / (360 * d));
            end
            return res;
        endfunction

        function void note_pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
            pending.push_back(convert(r, g, b));
        endfunction

        task check_hsv(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
            t_hsv e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat h=%0d s=%0d v=%0d", h, s, v));
            end else begin
                e = pending.pop_front();
                if (h !== e.hue) report($sformatf("hue %0d exp %0d", h, e.hue));
                if (s !== e.sat) report($sformatf("sat %0d exp %0d", s, e.sat));
                if (v !== e.val) report($sformatf("val %0d exp %0d", v, e.val));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [7:0] i_red = '0, i_green = '0, i_blue = '0;
    logic o_ready, o_valid;
    logic [7:0] o_hue, o_saturation, o_brightness;

    hsv_scoreboard sb = new();
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    int unsigned cycle = 0;

    always #5 i_clk = ~i_clk;

    rgb_to_hsv_pixel_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_hue(o_hue), .o_saturation(o_saturation), .o_brightness(o_brightness)
    );

    // monitor: sample at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_pixel(i_red, i_green, i_blue);
            if (o_valid && i_ready) sb.check_hsv(o_hue, o_saturation, o_brightness);
        end
    end

    // receiver stall pattern, changes on the falling edge
    initial begin
        int mode;
        mode = 0;
        @(negedge i_clk);
        forever begin
            if ((cycle % 2000) == 0) mode = $urandom_range(0, 2);
            if (hold_off) i_ready <= 1'b0;
            else if (mode == 0) i_ready <= 1'b1;
            else if (mode == 1) i_ready <= ($urandom_range(0, 3) != 0);
            else i_ready <= ($urandom_range(0, 3) == 0);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one beat: valid held until accepted
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        i_valid <= 1'b1;
        i_red <= r; i_green <= g; i_blue <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int burst;
        int sent;
        logic [7:0] dir[24][3];
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // black, white, greys, primaries, sector edges, wrap sector
        dir = '{'{0,0,0}, '{255,255,255}, '{128,128,128}, '{1,1,1},
                '{255,0,0}, '{0,255,0}, '{0,0,255}, '{255,255,0},
                '{0,255,255}, '{255,0,255}, '{255,0,1}, '{255,1,0},
                '{254,255,0}, '{0,254,255}, '{255,0,254}, '{1,0,0},
                '{0,0,1}, '{200,100,100}, '{100,200,100}, '{100,100,200},
                '{170,85,255}, '{85,255,170}, '{255,254,253}, '{2,1,0}};
        foreach (dir[k]) send_pixel(dir[k][0], dir[k][1], dir[k][2]);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (40) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        join
        drain();

        sent = 0;
        while (sent < 1800) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                case ($urandom_range(0, 5))
                    0: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 3)));
                    1: begin
                        logic [7:0] v;
                        v = 8'($urandom);
                        send_pixel(v, v, v);
                    end
                    2: send_pixel(8'($urandom_range(250, 255)),
                                  8'($urandom_range(250, 255)),
                                  8'($urandom_range(250, 255)));
                    default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                endcase
                sent++;
            end
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 12));
            if ($urandom_range(0, 60) == 0) drain();
        end
        drain();
        repeat (30) @(negedge i_clk);
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
